/* rtl/gdd_pkg.sv */
// Package: widths, constants and month table for the Gregorian date difference block.
`timescale 1ns / 1ps

package gdd_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int SPAN_W  = 22;
   localparam int ORD_W   = 23;
   localparam int DOY_W   = 9;
   localparam int C4_W    = 13;
   localparam int C100_W  = 8;
   localparam int YP_W    = YEAR_W + 1;
   localparam int MUL_W   = 16;
   localparam int PROD_W  = YP_W + MUL_W;
   localparam int DIV100_SHIFT = 22;

   localparam logic [MUL_W-1:0]  DIV100_MUL  = MUL_W'(((1 << DIV100_SHIFT) + 99) / 100);
   localparam logic [YP_W-1:0]   CENT_BIAS   = YP_W'(99);
   localparam logic [YP_W-1:0]   QUAD_BIAS   = YP_W'(3);
   localparam logic [DOY_W-1:0]  DAYS_YEAR   = DOY_W'(365);
   localparam logic [6:0]        CENT_YEARS  = 7'd100;
   localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
   localparam logic [MONTH_W-1:0] IDX_MAR    = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] IDX_FULL   = MONTH_W'(12);
   localparam logic [SPAN_W-1:0] SPAN_MAX    = '1;

   localparam int PIPE_DEPTH = 4;

   // month field to table index: zero acts as January, past December is the full year
   function automatic logic [MONTH_W-1:0] month_index(input logic [MONTH_W-1:0] m);
      logic [MONTH_W-1:0] idx;
      if (m == '0) begin
         idx = '0;
      end else if (m > MONTH_DEC) begin
         idx = IDX_FULL;
      end else begin
         idx = m - MONTH_JAN;
      end
      return idx;
   endfunction

   function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] idx);
      logic [DOY_W-1:0] v;
      unique case (idx)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd59;
         4'd3:    v = 9'd90;
         4'd4:    v = 9'd120;
         4'd5:    v = 9'd151;
         4'd6:    v = 9'd181;
         4'd7:    v = 9'd212;
         4'd8:    v = 9'd243;
         4'd9:    v = 9'd273;
         4'd10:   v = 9'd304;
         4'd11:   v = 9'd334;
         default: v = 9'd365;
      endcase
      return v;
   endfunction

endpackage

/* rtl/gregorian_date_difference.sv */
// Top level: two ordinal pipelines, then absolute difference with saturation.
// rsp_valid rises once the taken pair has passed the ordinal and span registers.
// Throughput: one date pair per cycle while busy is low; only reset raises busy.
// Each date runs through a 3-stage ordinal pipeline; a fourth stage forms the span.
// Reset: synchronous, active high; clears the valid chain, dropping any word in
// flight, and sets busy, which clears at the first clock with reset low.
`timescale 1ns / 1ps

module gregorian_date_difference
   import gdd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [YEAR_W-1:0]  req_first_year,
   input  logic [MONTH_W-1:0] req_first_month,
   input  logic [DAY_W-1:0]   req_first_day,
   input  logic [YEAR_W-1:0]  req_second_year,
   input  logic [MONTH_W-1:0] req_second_month,
   input  logic [DAY_W-1:0]   req_second_day,
   output logic               rsp_valid,
   output logic [SPAN_W-1:0]  rsp_day_span
);

   logic [ORD_W-1:0]      ord_a, ord_b, diff;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic [SPAN_W-1:0]     span_ff, span_in;
   logic                  busy_ff;

   gdd_ordinal u_ord_a (
      .clock   (clock),
      .year    (req_first_year),
      .month   (req_first_month),
      .day     (req_first_day),
      .ordinal (ord_a)
   );

   gdd_ordinal u_ord_b (
      .clock   (clock),
      .year    (req_second_year),
      .month   (req_second_month),
      .day     (req_second_day),
      .ordinal (ord_b)
   );

   always_comb begin
      diff     = (ord_a > ord_b) ? (ord_a - ord_b) : (ord_b - ord_a);
      span_in  = (diff > ORD_W'(SPAN_MAX)) ? SPAN_MAX : diff[SPAN_W-1:0];
      valid_in = {valid_ff[PIPE_DEPTH-2:0], start && !busy_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
   end

   assign busy         = busy_ff;
   assign rsp_valid    = valid_ff[PIPE_DEPTH-1];
   assign rsp_day_span = span_ff;

endmodule

/* rtl/gdd_ordinal.sv */
// Three-stage pipeline that turns one date into its ordinal day count.
`timescale 1ns / 1ps

module gdd_ordinal
   import gdd_pkg::*;
(
   input  logic               clock,
   input  logic [YEAR_W-1:0]  year,
   input  logic [MONTH_W-1:0] month,
   input  logic [DAY_W-1:0]   day,
   output logic [ORD_W-1:0]   ordinal
);

   // stage 1
   logic [YEAR_W-1:0] year1_ff;
   logic [DOY_W-1:0]  doy1_ff, doy1_in;
   logic              late1_ff, late1_in;
   logic [PROD_W-1:0] prod1_ff, prod1_in;
   logic [MONTH_W-1:0] idx;

   // stage 2
   logic [YEAR_W-1:0] year2_ff;
   logic [DOY_W-1:0]  doy2_ff;
   logic              late2_ff;
   logic [C100_W-1:0] c100_2_ff, c100_2_in;
   logic [ORD_W-1:0]  y365_2_ff, y365_2_in;
   logic [C4_W-1:0]   c4_2_ff, c4_2_in;

   // stage 3
   logic [ORD_W-1:0]  ord3_ff, ord3_in;
   logic [C100_W+6:0] cent_back;
   logic [C100_W-1:0] c400;
   logic              div100, leap;
   logic [YP_W-1:0]   year_q;

   always_comb begin
      idx      = month_index(month);
      doy1_in  = cum_days(idx) + DOY_W'(day);
      late1_in = (idx >= IDX_MAR);
      prod1_in = PROD_W'(YP_W'(year) + CENT_BIAS) * PROD_W'(DIV100_MUL);
   end

   always_comb begin
      c100_2_in = prod1_ff[DIV100_SHIFT +: C100_W];
      y365_2_in = ORD_W'(year1_ff) * ORD_W'(DAYS_YEAR);
      year_q    = YP_W'(year1_ff) + QUAD_BIAS;
      c4_2_in   = year_q[YP_W-1:2];
   end

   always_comb begin
      cent_back = (C100_W+7)'(c100_2_ff) * (C100_W+7)'(CENT_YEARS);
      div100    = (cent_back == (C100_W+7)'(year2_ff));
      leap      = (year2_ff[1:0] == 2'b00) && (!div100 || (c100_2_ff[1:0] == 2'b00));
      c400      = C100_W'((C100_W+1)'(c100_2_ff) + (C100_W+1)'(3) >> 2);
      ord3_in   = y365_2_ff + ORD_W'(c4_2_ff) - ORD_W'(c100_2_ff) + ORD_W'(c400)
                  + ORD_W'(doy2_ff) + ORD_W'(late2_ff && leap);
   end

   always_ff @(posedge clock) begin
      year1_ff  <= year;
      doy1_ff   <= doy1_in;
      late1_ff  <= late1_in;
      prod1_ff  <= prod1_in;
      year2_ff  <= year1_ff;
      doy2_ff   <= doy1_ff;
      late2_ff  <= late1_ff;
      c100_2_ff <= c100_2_in;
      y365_2_ff <= y365_2_in;
      c4_2_ff   <= c4_2_in;
      ord3_ff   <= ord3_in;
   end

   assign ordinal = ord3_ff;

endmodule

/* rtl/gdd_checker.sv */
// Port-level checker for the Gregorian date difference block, bound to the top level.
`timescale 1ns / 1ps

module gdd_checker
   import gdd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [YEAR_W-1:0]  req_first_year,
   input logic [MONTH_W-1:0] req_first_month,
   input logic [DAY_W-1:0]   req_first_day,
   input logic [YEAR_W-1:0]  req_second_year,
   input logic [MONTH_W-1:0] req_second_month,
   input logic [DAY_W-1:0]   req_second_day,
   input logic               rsp_valid,
   input logic [SPAN_W-1:0]  rsp_day_span
);

   logic take;
   assign take = start && !busy;

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      take |-> ##4 rsp_valid)
      else $error("accepted word produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, 4))
      else $error("result without accepted word");

   a_same_date: assert property (@(posedge clock) disable iff (reset)
      (take && req_first_year == req_second_year && req_first_month == req_second_month
       && req_first_day == req_second_day) |-> ##4 (rsp_day_span == '0))
      else $error("equal dates gave nonzero span");

   a_same_month: assert property (@(posedge clock) disable iff (reset)
      (take && req_first_year == req_second_year && req_first_month == req_second_month
       && req_first_day >= req_second_day)
      |-> ##4 (rsp_day_span == SPAN_W'($past(req_first_day, 4) - $past(req_second_day, 4))))
      else $error("same month span is not the day difference");

   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy high outside reset");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_first_year   (req_first_year),
   .req_first_month  (req_first_month),
   .req_first_day    (req_first_day),
   .req_second_year  (req_second_year),
   .req_second_month (req_second_month),
   .req_second_day   (req_second_day),
   .rsp_valid        (rsp_valid),
   .rsp_day_span     (rsp_day_span)
);
